### rtl/core/quaternion_arith_unit_top_defines.svh
// Assertion helpers for the quaternion unit checkers.
`ifndef QUATERNION_ARITH_UNIT_TOP_DEFINES_SVH
`define QUATERNION_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication
`define QAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/qau_pkg.sv
`default_nettype none

package qau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 32;
    localparam int LANES     = 4;
    localparam int TERMS     = 4;

    // product lane
    localparam int PROD_W = 2 * COMP_W;
    localparam int MSUM_W = PROD_W + 2;
    localparam int RND_W  = MSUM_W - FRAC_BITS;

    // sum of squares and square root
    localparam int SQ_W   = PROD_W + 1;
    localparam int ROOT_W = COMP_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;

    // divider
    localparam int NUM_W   = PROD_W;
    localparam int DIV_D_W = SQ_W;
    localparam int QB      = COMP_W + 1;
    localparam int QR_W    = QB + 1;

    // pipeline stage indexes
    localparam int ST_IN    = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_MERGE = 3;
    localparam int ST_SQRT0 = 3;
    localparam int ST_NORM  = ST_SQRT0 + ROOT_W;
    localparam int ST_DIV0  = ST_NORM + 1;
    localparam int ST_OUT   = ST_DIV0 + QB;
    localparam int N_ST     = ST_OUT + 1;

    typedef logic signed [COMP_W-1:0] t_comp;

    localparam t_comp COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam t_comp COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
    localparam logic signed [MSUM_W-1:0] MUL_HALF = MSUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [QR_W-1:0] QPOS_MAX = {{(QR_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic [QR_W-1:0] QNEG_MAX = QR_W'(1) << (COMP_W - 1);

    typedef enum logic [2:0] {
        OP_MUL       = 3'd0,
        OP_CONJ      = 3'd1,
        OP_NORM      = 3'd2,
        OP_NORMALIZE = 3'd3,
        OP_INV       = 3'd4
    } t_op;

    // Hamilton product terms: lane = result component, term j = a[IA] * b[IB]
    localparam logic [1:0] MUL_IA [LANES][TERMS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd1, 2'd2, 2'd0},
        '{2'd1, 2'd2, 2'd3, 2'd0}
    };
    localparam logic [1:0] MUL_IB [LANES][TERMS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd3, 2'd2, 2'd0, 2'd1},
        '{2'd1, 2'd3, 2'd0, 2'd2},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };
    // bit j set: term j is subtracted
    localparam logic [TERMS-1:0] MUL_NEG [LANES] = '{4'b1110, 4'b0010, 4'b0010, 4'b0010};

    typedef struct packed {
        logic [2:0] req_type;
        t_comp      a_w;
        t_comp      a_x;
        t_comp      a_y;
        t_comp      a_z;
        t_comp      b_w;
        t_comp      b_x;
        t_comp      b_y;
        t_comp      b_z;
    } t_req;

    typedef struct packed {
        t_comp             r_w;
        t_comp             r_x;
        t_comp             r_y;
        t_comp             r_z;
        logic [COMP_W-1:0] norm_value;
        logic              zero_divisor;
        logic              saturated;
    } t_resp;

    typedef struct packed {
        logic [TERMS-1:0][COMP_W-1:0] x;
        logic [TERMS-1:0][COMP_W-1:0] y;
        logic [TERMS-1:0]             neg;
        logic [COMP_W-1:0]            sqa;
    } t_mul_in;

    typedef struct packed {
        t_comp             r;
        logic              sat;
        logic [PROD_W-1:0] sq;
    } t_mul_out;

endpackage

`default_nettype wire

### rtl/core/qau_mul_lane.sv
`default_nettype none

module qau_mul_lane
    import qau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_en_prod,
    input  logic     i_en_sum,
    input  t_mul_in  i_mul,
    output t_mul_out o_mul
);

    logic signed [PROD_W-1:0] r_p [TERMS];
    logic [TERMS-1:0]         r_neg;
    logic [PROD_W-1:0]        r_sq;
    t_comp                    r_r;
    logic                     r_sat;

    logic signed [MSUM_W-1:0] n_sum;
    logic signed [MSUM_W-1:0] n_biased;
    logic [RND_W-1:0]         n_rnd;
    logic                     n_ovf;
    t_comp                    n_r;

    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            for (int j = 0; j < TERMS; j++) begin
                r_p[j] <= $signed(i_mul.x[j]) * $signed(i_mul.y[j]);
            end
            r_neg <= i_mul.neg;
            r_sq  <= $signed(i_mul.sqa) * $signed(i_mul.sqa);
        end
    end

    // exact sum, one rounding step, ties toward plus infinity
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < TERMS; j++) begin
            if (r_neg[j]) begin
                n_sum = n_sum - MSUM_W'(r_p[j]);
            end else begin
                n_sum = n_sum + MSUM_W'(r_p[j]);
            end
        end
        n_biased = n_sum + MUL_HALF;
        n_rnd    = n_biased[MSUM_W-1:FRAC_BITS];
        n_ovf    = !(&n_rnd[RND_W-1:COMP_W-1]) && (|n_rnd[RND_W-1:COMP_W-1]);
        if (n_ovf) begin
            n_r = n_rnd[RND_W-1] ? COMP_MIN : COMP_MAX;
        end else begin
            n_r = n_rnd[COMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_r   <= n_r;
            r_sat <= n_ovf;
        end
    end

    assign o_mul.r   = r_r;
    assign o_mul.sat = r_sat;
    assign o_mul.sq  = r_sq;

endmodule

`default_nettype wire

### rtl/core/qau_sqrt.sv
`default_nettype none

module qau_sqrt
    import qau_pkg::*;
(
    input  logic              i_clk,
    input  logic [ROOT_W-1:0] i_en,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root,
    output logic [SREM_W-1:0] o_rem
);

    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SREM_W-1:0] r_rem  [ROOT_W];

    // one root bit per stage
    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic [RAD_W-1:0]  w_rad;
        logic [ROOT_W-1:0] w_root;
        logic [SREM_W-1:0] w_rem;
        logic [SREM_W+1:0] w_cur;
        logic [SREM_W+1:0] w_trial;

        if (i == 0) begin : g_first
            assign w_rad  = i_rad;
            assign w_root = '0;
            assign w_rem  = '0;
        end else begin : g_next
            assign w_rad  = r_rad[i-1];
            assign w_root = r_root[i-1];
            assign w_rem  = r_rem[i-1];
        end

        assign w_cur   = {w_rem, w_rad[RAD_W-1 -: 2]};
        assign w_trial = {2'b00, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_rad[i] <= w_rad << 2;
                if (w_cur >= w_trial) begin
                    r_rem[i]  <= SREM_W'(w_cur - w_trial);
                    r_root[i] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[i]  <= SREM_W'(w_cur);
                    r_root[i] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
    assign o_rem  = r_rem[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/qau_div_lane.sv
`default_nettype none

module qau_div_lane
    import qau_pkg::*;
(
    input  logic               i_clk,
    input  logic [QB-1:0]      i_en,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DIV_D_W-1:0] i_den,
    input  logic [DIV_D_W-1:0] i_den_pipe [QB],
    output logic [QR_W-1:0]    o_quo
);

    logic [DIV_D_W-1:0] r_rem [QB];
    logic [QB-1:0]      r_num [QB];
    logic [QB-1:0]      r_quo [QB];
    logic               w_up;

    // restoring division, one quotient bit per stage; the quotient is known
    // to stay below 2^QB, so the top numerator bits seed the remainder
    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [DIV_D_W-1:0] w_rem;
        logic [QB-1:0]      w_num;
        logic [QB-1:0]      w_quo;
        logic [DIV_D_W-1:0] w_den;
        logic [DIV_D_W:0]   w_cur;
        logic               w_ge;

        if (j == 0) begin : g_first
            assign w_rem = DIV_D_W'(i_num[NUM_W-1:QB]);
            assign w_num = i_num[QB-1:0];
            assign w_quo = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_num = r_num[j-1];
            assign w_quo = r_quo[j-1];
            assign w_den = i_den_pipe[j-1];
        end

        assign w_cur = {w_rem, w_num[QB-1]};
        assign w_ge  = w_cur >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_num[j] <= w_num << 1;
                r_quo[j] <= {w_quo[QB-2:0], w_ge};
                r_rem[j] <= w_ge ? DIV_D_W'(w_cur - {1'b0, w_den}) : DIV_D_W'(w_cur);
            end
        end
    end

    // round to nearest, ties away from zero
    assign w_up  = {r_rem[QB-1], 1'b0} >= {1'b0, i_den_pipe[QB-1]};
    assign o_quo = QR_W'(r_quo[QB-1]) + QR_W'(w_up);

endmodule

`default_nettype wire

### rtl/core/quaternion_arith_unit_top.sv
// Quaternion arithmetic unit, signed Q16.16 components.
// Request channel (i_req_valid / o_req_ready / i_req): operation code and
// quaternions a and b (b is read by multiply only). Response channel
// (o_resp_valid / i_resp_ready / o_resp): one response per request, in order.
// Operations: multiply, conjugate, norm, normalize, inverse.
// Throughput: one request per cycle, sustained while responses are taken,
// for any operation mix. The pipeline runs through the square root
// (33 stages, one root bit each) followed by the four divider lanes
// (33 stages, one quotient bit each); multiply and conjugate ride the
// same pipeline so responses stay in order.
// Stalls: each stage advances when the response is taken or any stage at or
// after it is empty, so bubbles collapse while o_resp_valid waits; o_req_ready
// drops only when every stage holds a request and the response is not taken.
// Reset (i_rst_n low, synchronous) empties the pipeline; in-flight requests
// are dropped and no response is pending afterwards.
`default_nettype none

module quaternion_arith_unit_top
    import qau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_req  i_req,
    output logic  o_resp_valid,
    input  logic  i_resp_ready,
    output t_resp o_resp
);

    typedef struct packed {
        logic [2:0]                   op;
        logic [LANES-1:0][COMP_W-1:0] mr;
        logic                         msat;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][COMP_W-1:0] mag;
        logic [SQ_W-1:0]              s;
        logic [ROOT_W-1:0]            n;
        logic [COMP_W-1:0]            normv;
        logic                         nsat;
    } t_side;

    logic [N_ST-1:0]    r_vld;
    logic [N_ST-1:0]    w_adv;
    t_req               r_req;
    t_side              r_side    [1:ST_OUT-1];
    t_side              w_side_nx [1:ST_OUT-1];
    t_side              w_side1;
    t_side              w_side2;
    t_side              w_side3;
    t_side              w_siden;
    t_resp              r_resp;
    t_resp              n_resp;

    t_comp              w_a [LANES];
    t_comp              w_b [LANES];
    t_mul_in            w_mul_in  [LANES];
    t_mul_out           w_mul_out [LANES];

    logic [ROOT_W-1:0]  w_root;
    logic [SREM_W-1:0]  w_srem;
    logic [DIV_D_W-1:0] w_den;
    logic [NUM_W-1:0]   w_num [LANES];
    logic [DIV_D_W-1:0] r_dpipe [QB];
    logic [QR_W-1:0]    w_quo [LANES];

    // ---- flow control ----
    always_comb begin
        logic [N_ST-1:0] low;
        for (int k = 0; k < N_ST; k++) begin
            low      = ~({N_ST{1'b1}} << k);
            w_adv[k] = i_resp_ready || !(&(r_vld | low));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[ST_IN]) begin
                r_vld[ST_IN] <= i_req_valid;
            end
            for (int k = 1; k < N_ST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_req_ready  = w_adv[ST_IN];
    assign o_resp_valid = r_vld[ST_OUT];
    assign o_resp       = r_resp;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_IN]) begin
            r_req <= i_req;
        end
    end

    // ---- product stage ----
    assign w_a[0] = r_req.a_w;
    assign w_a[1] = r_req.a_x;
    assign w_a[2] = r_req.a_y;
    assign w_a[3] = r_req.a_z;
    assign w_b[0] = r_req.b_w;
    assign w_b[1] = r_req.b_x;
    assign w_b[2] = r_req.b_y;
    assign w_b[3] = r_req.b_z;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int j = 0; j < TERMS; j++) begin
                w_mul_in[k].x[j] = w_a[MUL_IA[k][j]];
                w_mul_in[k].y[j] = w_b[MUL_IB[k][j]];
            end
            w_mul_in[k].neg = MUL_NEG[k];
            w_mul_in[k].sqa = w_a[k];
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_mul
        qau_mul_lane u_mul (
            .i_clk     (i_clk),
            .i_en_prod (w_adv[ST_PROD]),
            .i_en_sum  (w_adv[ST_SUM]),
            .i_mul     (w_mul_in[k]),
            .o_mul     (w_mul_out[k])
        );
    end

    // conjugate, magnitudes and result signs for the divider
    always_comb begin
        w_side1      = '0;
        w_side1.op   = r_req.req_type;
        for (int i = 0; i < LANES; i++) begin
            w_side1.mag[i] = w_a[i][COMP_W-1] ? COMP_W'(-w_a[i]) : w_a[i];
            w_side1.neg[i] = w_a[i][COMP_W-1] ^ ((r_req.req_type == OP_INV) && (i > 0));
        end
        if (r_req.req_type == OP_CONJ) begin
            w_side1.mr[0] = w_a[0];
            for (int i = 1; i < LANES; i++) begin
                if (w_a[i] == COMP_MIN) begin
                    w_side1.mr[i] = COMP_MAX;
                    w_side1.msat  = 1'b1;
                end else begin
                    w_side1.mr[i] = -w_a[i];
                end
            end
        end
    end

    // ---- sum of squares ----
    always_comb begin
        w_side2   = r_side[ST_PROD];
        w_side2.s = '0;
        for (int k = 0; k < LANES; k++) begin
            w_side2.s = w_side2.s + SQ_W'(w_mul_out[k].sq);
        end
    end

    // ---- product results join the side band ----
    always_comb begin
        w_side3 = r_side[ST_MERGE-1];
        if (w_side3.op == OP_MUL) begin
            w_side3.msat = 1'b0;
            for (int k = 0; k < LANES; k++) begin
                w_side3.mr[k] = w_mul_out[k].r;
                w_side3.msat  = w_side3.msat | w_mul_out[k].sat;
            end
        end
    end

    // ---- square root ----
    qau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv[ST_SQRT0 +: ROOT_W]),
        .i_rad  (RAD_W'(r_side[ST_SUM].s)),
        .o_root (w_root),
        .o_rem  (w_srem)
    );

    // nearest integer root
    always_comb begin
        w_siden   = r_side[ST_NORM-1];
        w_siden.n = w_root + ROOT_W'(w_srem > SREM_W'(w_root));
        if (w_siden.op == OP_NORM) begin
            w_siden.nsat  = w_siden.n[ROOT_W-1];
            w_siden.normv = w_siden.n[ROOT_W-1] ? '1 : w_siden.n[COMP_W-1:0];
        end
    end

    for (genvar k = 1; k < ST_OUT; k++) begin : g_side
        if (k == ST_PROD) begin : g_s1
            assign w_side_nx[k] = w_side1;
        end else if (k == ST_SUM) begin : g_s2
            assign w_side_nx[k] = w_side2;
        end else if (k == ST_MERGE) begin : g_s3
            assign w_side_nx[k] = w_side3;
        end else if (k == ST_NORM) begin : g_sn
            assign w_side_nx[k] = w_siden;
        end else begin : g_sp
            assign w_side_nx[k] = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_side[k] <= w_side_nx[k];
            end
        end
    end

    // ---- divider lanes ----
    // normalize: (|a| << F) / n; inverse: (|a| << 2F) / s
    always_comb begin
        if (r_side[ST_NORM].op == OP_NORMALIZE) begin
            w_den = DIV_D_W'(r_side[ST_NORM].n);
        end else begin
            w_den = r_side[ST_NORM].s;
        end
        for (int k = 0; k < LANES; k++) begin
            if (r_side[ST_NORM].op == OP_NORMALIZE) begin
                w_num[k] = NUM_W'(r_side[ST_NORM].mag[k]) << FRAC_BITS;
            end else begin
                w_num[k] = NUM_W'(r_side[ST_NORM].mag[k]) << (2 * FRAC_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_DIV0]) begin
            r_dpipe[0] <= w_den;
        end
        for (int j = 1; j < QB; j++) begin
            if (w_adv[ST_DIV0 + j]) begin
                r_dpipe[j] <= r_dpipe[j-1];
            end
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_div
        qau_div_lane u_div (
            .i_clk      (i_clk),
            .i_en       (w_adv[ST_DIV0 +: QB]),
            .i_num      (w_num[k]),
            .i_den      (w_den),
            .i_den_pipe (r_dpipe),
            .o_quo      (w_quo[k])
        );
    end

    // ---- merge ----
    always_comb begin
        t_side sd;
        t_comp rc [LANES];
        logic  sat;
        logic  zd;
        logic  qneg;
        sd   = r_side[ST_OUT-1];
        sat  = 1'b0;
        zd   = 1'b0;
        qneg = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            rc[k] = '0;
        end
        n_resp = '0;
        case (sd.op) inside
            OP_MUL, OP_CONJ: begin
                for (int k = 0; k < LANES; k++) begin
                    rc[k] = sd.mr[k];
                end
                sat = sd.msat;
            end
            OP_NORM: begin
                n_resp.norm_value = sd.normv;
                sat               = sd.nsat;
            end
            OP_NORMALIZE, OP_INV: begin
                if (sd.s == '0) begin
                    zd = 1'b1;
                end else begin
                    for (int k = 0; k < LANES; k++) begin
                        qneg = sd.neg[k] && (w_quo[k] != '0);
                        if (qneg) begin
                            if (w_quo[k] > QNEG_MAX) begin
                                rc[k] = COMP_MIN;
                                sat   = 1'b1;
                            end else begin
                                rc[k] = -w_quo[k][COMP_W-1:0];
                            end
                        end else if (w_quo[k] > QPOS_MAX) begin
                            rc[k] = COMP_MAX;
                            sat   = 1'b1;
                        end else begin
                            rc[k] = w_quo[k][COMP_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_resp.r_w          = rc[0];
        n_resp.r_x          = rc[1];
        n_resp.r_y          = rc[2];
        n_resp.r_z          = rc[3];
        n_resp.zero_divisor = zd;
        n_resp.saturated    = sat;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_resp <= n_resp;
        end
    end

endmodule

`default_nettype wire

### rtl/core/qau_checker.sv
`default_nettype none

`include "quaternion_arith_unit_top_defines.svh"

module qau_checker
    import qau_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_req_valid,
    input logic  o_req_ready,
    input t_req  i_req,
    input logic  o_resp_valid,
    input logic  i_resp_ready,
    input t_resp o_resp
);

    `QAU_ASSERT_NEXT(a_resp_hold, i_clk, i_rst_n, o_resp_valid && !i_resp_ready,
        o_resp_valid && $stable(o_resp), "stalled response changed or vanished")

    // input backs up only when the whole pipeline is full and stalled
    `QAU_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !o_req_ready,
        o_resp_valid && !i_resp_ready, "request blocked without a stalled response")

    `QAU_ASSERT_IMP(a_zd_zero, i_clk, i_rst_n, o_resp_valid && o_resp.zero_divisor,
        o_resp.r_w == '0 && o_resp.r_x == '0 && o_resp.r_y == '0 && o_resp.r_z == '0
        && !o_resp.saturated, "zero divisor response not cleared")

    `QAU_ASSERT_IMP(a_norm_only, i_clk, i_rst_n, o_resp_valid && o_resp.norm_value != '0,
        o_resp.r_w == '0 && o_resp.r_x == '0 && o_resp.r_y == '0 && o_resp.r_z == '0
        && !o_resp.zero_divisor, "norm response carries component data")

endmodule

bind quaternion_arith_unit_top qau_checker u_qau_checker (.*);

`default_nettype wire

### verif/quaternion_arith_unit_top_tb.sv
`default_nettype none

module quaternion_arith_unit_top_tb;
    import qau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 950;
    localparam int  CYC_LIMIT  = 200000;
    localparam int  HOLD_AT    = 600;
    localparam int  HOLD_LEN   = 400;
    localparam int  DRAIN_CYC  = 200;
    localparam logic [2:0] OP_RSV5 = 3'd5;
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;
    localparam t_comp ONE = 32'h0001_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_ready;
    t_req  i_req = '0;
    logic  o_resp_valid;
    logic  i_resp_ready = 1'b0;
    t_resp o_resp;

    quaternion_arith_unit_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp)
    );

    always #5 i_clk = ~i_clk;

    typedef struct {
        t_req  req;
        bit    typed;
        t_resp rsp;
    } t_vec;

    t_resp pending_q[$];
    t_vec  dir_tab[$];
    int    cyc = 0;
    int    n_err = 0;
    int    n_resp = 0;
    int    n_zdiv = 0;
    int    n_sat = 0;
    bit    sender_done = 1'b0;

    // ---------------- predictor ----------------
    function automatic t_comp clip32(logic signed [71:0] v, inout bit sat);
        if (v > 72'sd2147483647) begin
            sat = 1'b1;
            return COMP_MAX;
        end
        if (v < -72'sd2147483648) begin
            sat = 1'b1;
            return COMP_MIN;
        end
        return t_comp'(v);
    endfunction

    function automatic logic signed [71:0] prod(longint x, longint y);
        logic signed [71:0] p;
        p = x;
        p = p * y;
        return p;
    endfunction

    function automatic logic [71:0] root_floor(logic [71:0] s);
        logic [71:0] r;
        logic [71:0] t;
        r = '0;
        for (int i = 34; i >= 0; i--) begin
            t = r | (72'd1 << i);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // rounded quotient magnitude, half away from zero, folded back to a signed lane
    function automatic t_comp lane_quot(bit neg, logic [127:0] num, logic [127:0] den,
                                        inout bit sat);
        logic [127:0] qt;
        qt = (2 * num + den) / (2 * den);
        if (qt == 0) neg = 1'b0;
        if (neg) begin
            if (qt > 128'h8000_0000) begin
                sat = 1'b1;
                return COMP_MIN;
            end
            return t_comp'(-qt);
        end
        if (qt > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return COMP_MAX;
        end
        return t_comp'(qt);
    endfunction

    function automatic t_resp quat_result(t_req q);
        longint a[4];
        longint b[4];
        logic signed [71:0] acc[4];
        logic [71:0] ssq;
        logic [71:0] nr;
        logic [127:0] num;
        logic [127:0] den;
        t_comp r[4];
        bit sat;
        bit neg;
        t_resp o;
        a = '{q.a_w, q.a_x, q.a_y, q.a_z};
        b = '{q.b_w, q.b_x, q.b_y, q.b_z};
        r = '{default: '0};
        sat = 1'b0;
        o = '0;
        case (q.req_type)
            OP_MUL: begin
                acc[0] = prod(a[0], b[0]) - prod(a[1], b[1]) - prod(a[2], b[2])
                       - prod(a[3], b[3]);
                acc[1] = prod(a[0], b[1]) + prod(a[1], b[0]) + prod(a[2], b[3])
                       - prod(a[3], b[2]);
                acc[2] = prod(a[0], b[2]) - prod(a[1], b[3]) + prod(a[2], b[0])
                       + prod(a[3], b[1]);
                acc[3] = prod(a[0], b[3]) + prod(a[1], b[2]) - prod(a[2], b[1])
                       + prod(a[3], b[0]);
                // round half up, then clip
                for (int i = 0; i < 4; i++)
                    r[i] = clip32((acc[i] + 72'sd32768) >>> FRAC_BITS, sat);
            end
            OP_CONJ: begin
                r[0] = q.a_w;
                for (int i = 1; i < 4; i++) r[i] = clip32(-prod(a[i], 1), sat);
            end
            OP_NORM, OP_NORMALIZE, OP_INV: begin
                ssq = '0;
                for (int i = 0; i < 4; i++) ssq += 72'(prod(a[i], a[i]));
                nr = root_floor(ssq);
                if (ssq - nr * nr > nr) nr++;
                if (q.req_type == OP_NORM) begin
                    if (nr > 72'hFFFF_FFFF) begin
                        nr = 72'hFFFF_FFFF;
                        sat = 1'b1;
                    end
                    o.norm_value = nr[31:0];
                end else if (ssq == 0) begin
                    o.zero_divisor = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        neg = a[i] < 0;
                        num = (a[i] < 0) ? 128'(-a[i]) : 128'(a[i]);
                        if (q.req_type == OP_NORMALIZE) begin
                            num = num << FRAC_BITS;
                            den = 128'(nr);
                        end else begin
                            num = num << (2 * FRAC_BITS);
                            den = 128'(ssq);
                            if (i > 0) neg = !neg;
                        end
                        r[i] = lane_quot(neg, num, den, sat);
                    end
                end
            end
            default: ;
        endcase
        o.r_w = r[0];
        o.r_x = r[1];
        o.r_y = r[2];
        o.r_z = r[3];
        o.saturated = sat;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic t_req mk_req(logic [2:0] op, t_comp aw, t_comp ax, t_comp ay,
                                    t_comp az, t_comp bw, t_comp bx, t_comp by, t_comp bz);
        t_req q;
        q = '{op, aw, ax, ay, az, bw, bx, by, bz};
        return q;
    endfunction

    function automatic t_resp mk_rsp(t_comp rw, t_comp rx, t_comp ry, t_comp rz,
                                     logic [31:0] nv, logic zd, logic st);
        t_resp o;
        o = '{rw, rx, ry, rz, nv, zd, st};
        return o;
    endfunction

    function automatic void add_row(t_req q, bit typed, t_resp e);
        t_vec v;
        v.req = q;
        v.typed = typed;
        v.rsp = e;
        dir_tab.push_back(v);
    endfunction

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 9))
            0: return COMP_MIN;
            1: return COMP_MAX;
            2: return '0;
            3: return t_comp'($urandom_range(0, 32'h3_0000));
            4: return -t_comp'($urandom_range(0, 32'h3_0000));
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q.req_type = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        q.a_w = rand_comp();
        q.a_x = rand_comp();
        q.a_y = rand_comp();
        q.a_z = rand_comp();
        q.b_w = rand_comp();
        q.b_x = rand_comp();
        q.b_y = rand_comp();
        q.b_z = rand_comp();
        return q;
    endfunction

    // offer one request; acceptance is judged at the rising edge
    task automatic offer(t_req q, t_resp e);
        i_req = q;
        i_req_valid = 1'b1;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        pending_q.push_back(e);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) != 0) begin
            i_req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // ---------------- sender ----------------
    initial begin
        t_req q;
        int burst;
        int sent;
        add_row(mk_req(OP_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0), 1, mk_rsp(ONE, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_MUL, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                       COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX), 0, '0);
        add_row(mk_req(OP_MUL, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                       COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN), 0, '0);
        add_row(mk_req(OP_MUL, COMP_MIN, COMP_MAX, -1, 1, COMP_MAX, COMP_MIN, 1, -1), 0, '0);
        add_row(mk_req(OP_CONJ, ONE, COMP_MIN, 2, -3, 0, 0, 0, 0), 1,
                mk_rsp(ONE, COMP_MAX, -2, 3, 0, 0, 1));
        add_row(mk_req(OP_CONJ, 0, 0, 0, 0, COMP_MAX, 1, 1, 1), 1, '0);
        add_row(mk_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0);
        add_row(mk_req(OP_NORM, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0, 0, 0, 0), 1,
                mk_rsp(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1));
        add_row(mk_req(OP_NORM, 3, 4, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 5, 0, 0));
        add_row(mk_req(OP_NORM, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_NORMALIZE, 0, 0, 0, 0, 5, 5, 5, 5), 1,
                mk_rsp(0, 0, 0, 0, 0, 1, 0));
        add_row(mk_req(OP_NORMALIZE, ONE, 0, 0, 0, 0, 0, 0, 0), 1,
                mk_rsp(ONE, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_NORMALIZE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0, 0, 0, 0),
                0, '0);
        add_row(mk_req(OP_NORMALIZE, 0, COMP_MAX, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_NORMALIZE, 1, -1, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_INV, 0, 0, 0, 0, 1, 1, 1, 1), 1, mk_rsp(0, 0, 0, 0, 0, 1, 0));
        add_row(mk_req(OP_INV, ONE, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(ONE, 0, 0, 0, 0, 0, 0));
        add_row(mk_req(OP_INV, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_INV, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_INV, 0, COMP_MIN, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(OP_RSV5, ONE, 7, -7, COMP_MIN, 1, 2, 3, 4), 1, '0);
        add_row(mk_req(OP_RSV6, COMP_MAX, 1, 2, 3, 4, 5, 6, 7), 1, '0);
        add_row(mk_req(OP_RSV7, -1, -1, -1, -1, -1, -1, -1, -1), 1, '0);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) begin
            offer(dir_tab[k].req, dir_tab[k].typed ? dir_tab[k].rsp
                                                    : quat_result(dir_tab[k].req));
            if ($urandom_range(0, 2) == 0) idle_gap();
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
                q = rand_req();
                offer(q, quat_result(q));
                sent++;
            end
            idle_gap();
        end
        i_req_valid = 1'b0;
        sender_done = 1'b1;
    end

    // ---------------- receiver: stall pattern plus one long hold-off ----------------
    initial begin
        int rcyc;
        int mode;
        int hold;
        rcyc = 0;
        mode = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            rcyc++;
            if (rcyc == HOLD_AT) hold = HOLD_LEN;
            if (rcyc % 64 == 0) mode = $urandom_range(0, 3);
            if (hold > 0) begin
                hold--;
                i_resp_ready = 1'b0;
            end else begin
                case (mode)
                    0: i_resp_ready = 1'b1;
                    1: i_resp_ready = ($urandom_range(0, 9) < 7);
                    2: i_resp_ready = (rcyc % 5 != 0);
                    default: i_resp_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------- response check ----------------
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && o_resp_valid && i_resp_ready) begin
            n_resp++;
            if (pending_q.size() == 0) begin
                $display("%0t: response with nothing outstanding, got %p", $time, o_resp);
                n_err++;
            end else begin
                e = pending_q.pop_front();
                n_zdiv += e.zero_divisor;
                n_sat += e.saturated;
                if (o_resp !== e) begin
                    n_err++;
                    if (o_resp.r_w !== e.r_w)
                        $display("%0t: r_w exp %h got %h", $time, e.r_w, o_resp.r_w);
                    if (o_resp.r_x !== e.r_x)
                        $display("%0t: r_x exp %h got %h", $time, e.r_x, o_resp.r_x);
                    if (o_resp.r_y !== e.r_y)
                        $display("%0t: r_y exp %h got %h", $time, e.r_y, o_resp.r_y);
                    if (o_resp.r_z !== e.r_z)
                        $display("%0t: r_z exp %h got %h", $time, e.r_z, o_resp.r_z);
                    if (o_resp.norm_value !== e.norm_value)
                        $display("%0t: norm_value exp %h got %h", $time, e.norm_value,
                                 o_resp.norm_value);
                    if (o_resp.zero_divisor !== e.zero_divisor)
                        $display("%0t: zero_divisor exp %b got %b", $time, e.zero_divisor,
                                 o_resp.zero_divisor);
                    if (o_resp.saturated !== e.saturated)
                        $display("%0t: saturated exp %b got %b", $time, e.saturated,
                                 o_resp.saturated);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("timeout at cycle %0d, %0d requests outstanding", cyc, pending_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- end of run ----------------
    initial begin
        wait (sender_done);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("%0d responses checked (%0d directed rows), %0d zero-divisor, %0d saturated",
                 n_resp, dir_tab.size(), n_zdiv, n_sat);
        $display("covered all five operations plus reserved codes, with input and output stalls");
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", n_err);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/qau_pkg.sv
rtl/core/qau_mul_lane.sv
rtl/core/qau_sqrt.sv
rtl/core/qau_div_lane.sv
rtl/core/quaternion_arith_unit_top.sv
rtl/core/qau_checker.sv
verif/quaternion_arith_unit_top_tb.sv
